FILE: hdl/sws_pkg.sv
`timescale 1ns / 1ps
// sws_pkg: shared widths, word type and scan control struct for the
// sliding window statistics block. No dependencies.
package sws_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned FILL_W = 5;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [FILL_W-1:0] fill_t;

  // control from the sequencer to the scan accumulator
  typedef struct packed {
    logic clear;
    logic valid;
    logic odd;
  } scan_ctl_t;

endpackage

FILE: hdl/sws_chan_if.sv
`timescale 1ns / 1ps
// sws_in_if and sws_out_if: valid/ready channels that carry one sample word
// in and one statistics word out. Depends on sws_pkg.
interface sws_in_if import sws_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface sws_out_if import sws_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t mean_value;
  word_t min_value;
  word_t max_value;
  word_t pair_low;
  word_t pair_high;
  fill_t fill_count;

  modport source (output valid, output mean_value, output min_value, output max_value,
                  output pair_low, output pair_high, output fill_count, input ready);
  modport sink (input valid, input mean_value, input min_value, input max_value,
                input pair_low, input pair_high, input fill_count, output ready);
endinterface

FILE: hdl/sws_div.sv
`timescale 1ns / 1ps
// sws_div: iterative restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module sws_div #(
  parameter int unsigned NUM_W = 37,
  parameter int unsigned DEN_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W);
  localparam logic [STEP_W-1:0] LastStep = STEP_W'(NUM_W - 1);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [DEN_W-1:0]  rem_q, den_q, rem_next;
  logic [NUM_W-1:0]  quot_q;
  logic [DEN_W:0]    trial;
  logic              fits;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial    = {rem_q, quot_q[NUM_W-1]};
    fits     = trial >= {1'b0, den_q};
    rem_next = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits shift in where dividend bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      den_q  <= den_i;
      quot_q <= num_i;
    end else if (busy_q) begin
      rem_q  <= rem_next;
      quot_q <= {quot_q[NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: hdl/sws_scan.sv
`timescale 1ns / 1ps
// sws_scan: accumulates min, max and the even and odd position sums over
// the words read back from the window store. Depends on sws_pkg.
module sws_scan import sws_pkg::*; #(
  parameter int unsigned SUM_W = 37
) (
  input  logic             clk_i,
  input  scan_ctl_t        ctl_i,
  input  word_t            data_i,
  output word_t            min_o,
  output word_t            max_o,
  output logic [SUM_W-1:0] even_sum_o,
  output logic [SUM_W-1:0] odd_sum_o
);

  word_t            min_q, max_q;
  logic [SUM_W-1:0] even_q, odd_q;

  // one word per cycle while valid
  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      min_q  <= '1;
      max_q  <= '0;
      even_q <= '0;
      odd_q  <= '0;
    end else if (ctl_i.valid) begin
      if (data_i < min_q) min_q <= data_i;
      if (data_i > max_q) max_q <= data_i;
      if (ctl_i.odd) begin
        odd_q <= odd_q + SUM_W'(data_i);
      end else begin
        even_q <= even_q + SUM_W'(data_i);
      end
    end
  end

  assign min_o      = min_q;
  assign max_o      = max_q;
  assign even_sum_o = even_q;
  assign odd_sum_o  = odd_q;

endmodule

FILE: hdl/sliding_window_stats.sv
`timescale 1ns / 1ps
// sliding_window_stats: mean, min, max and even/odd position averages over
// the last WINDOW samples. A new sample is taken only in idle, once the result
// word for the previous one is loaded into the output register; the time between
// is set by the store scan, up to three serial divides and output back-pressure.
// Reset empties the window.
module sliding_window_stats import sws_pkg::*; #(
  parameter int unsigned WINDOW = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sws_in_if.sink    in_i,
  sws_out_if.source out_o
);

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = DATA_W + CNT_W;
  localparam logic [CNT_W-1:0]  WinCnt = CNT_W'(WINDOW);
  localparam logic [SLOT_W:0]   WinPos = (SLOT_W + 1)'(WINDOW);
  localparam logic [SLOT_W-1:0] LastSlot = SLOT_W'(WINDOW - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RDOLD = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DIVM  = 3'd3;
  localparam logic [2:0] ST_DIVE  = 3'd4;
  localparam logic [2:0] ST_DIVO  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [SLOT_W-1:0] oldest_q, oldest_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  word_t             sample_q;
  word_t             mean_q, mean_d, even_avg_q, even_avg_d, odd_avg_q, odd_avg_d;
  logic              issue_q, par_q;
  logic              out_valid_q, out_valid_d, out_load;
  word_t             omean_q, omin_q, omax_q, olow_q, ohigh_q;
  fill_t             ofill_q;

  // window store
  word_t             store_mem [WINDOW];
  word_t             mem_rdata_q, mem_wdata;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr, mem_raddr;

  logic              in_accept, issue, scan_done;
  logic [SLOT_W:0]   app_pos, scan_pos;
  logic [SLOT_W-1:0] app_slot, scan_slot;
  logic [CNT_W:0]    count_inc;
  logic [CNT_W-1:0]  even_n, odd_n;
  scan_ctl_t         scan_ctl;
  word_t             scan_min, scan_max;
  logic [SUM_W-1:0]  even_sum, odd_sum;
  logic              div_start, div_done;
  logic [SUM_W-1:0]  div_num, div_quot;
  logic [CNT_W-1:0]  div_den;
  word_t             pair_lo, pair_hi;

  assign in_accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  // slot arithmetic: oldest stays below WINDOW and the offset at most WINDOW, so one subtract wraps
  assign app_pos   = {1'b0, oldest_q} + (SLOT_W + 1)'(count_q);
  assign app_slot  = (app_pos >= WinPos) ? SLOT_W'(app_pos - WinPos) : app_pos[SLOT_W-1:0];
  assign scan_pos  = {1'b0, oldest_q} + (SLOT_W + 1)'(idx_q);
  assign scan_slot = (scan_pos >= WinPos) ? SLOT_W'(scan_pos - WinPos) : scan_pos[SLOT_W-1:0];

  // group sizes by position parity
  assign count_inc = {1'b0, count_q} + 1'b1;
  assign even_n    = count_inc[CNT_W:1];
  assign odd_n     = count_q >> 1;

  assign issue     = (state_q == ST_SCAN) && (idx_q != count_q);
  assign scan_done = (state_q == ST_SCAN) && (idx_q == count_q) && !issue_q;

  // store port
  always_ff @(posedge clk_i) begin
    if (mem_we) store_mem[mem_waddr] <= mem_wdata;
    mem_rdata_q <= store_mem[mem_raddr];
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    oldest_d   = oldest_q;
    count_d    = count_q;
    idx_d      = idx_q;
    sum_d      = sum_q;
    mean_d     = mean_q;
    even_avg_d = even_avg_q;
    odd_avg_d  = odd_avg_q;
    mem_we     = 1'b0;
    mem_waddr  = app_slot;
    mem_wdata  = in_i.sample;
    mem_raddr  = (state_q == ST_SCAN) ? scan_slot : oldest_q;
    div_start  = 1'b0;
    div_num    = sum_q;
    div_den    = count_q;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          idx_d = '0;
          if (count_q == WinCnt) begin
            state_d = ST_RDOLD;
          end else begin
            mem_we  = 1'b1;
            sum_d   = sum_q + SUM_W'(in_i.sample);
            count_d = count_q + 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_RDOLD: begin
        // oldest word is in the read register: swap it out of the sum
        mem_we    = 1'b1;
        mem_waddr = oldest_q;
        mem_wdata = sample_q;
        sum_d     = sum_q - SUM_W'(mem_rdata_q) + SUM_W'(sample_q);
        oldest_d  = (oldest_q == LastSlot) ? '0 : oldest_q + 1'b1;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        if (issue) idx_d = idx_q + 1'b1;
        if (scan_done) begin
          div_start = 1'b1;
          state_d   = ST_DIVM;
        end
      end
      ST_DIVM: begin
        if (div_done) begin
          mean_d    = div_quot[DATA_W-1:0];
          div_start = 1'b1;
          div_num   = even_sum;
          div_den   = even_n;
          state_d   = ST_DIVE;
        end
      end
      ST_DIVE: begin
        if (div_done) begin
          even_avg_d = div_quot[DATA_W-1:0];
          if (odd_n == '0) begin
            // empty odd group averages to zero
            odd_avg_d = '0;
            state_d   = ST_OUT;
          end else begin
            div_start = 1'b1;
            div_num   = odd_sum;
            div_den   = odd_n;
            state_d   = ST_DIVO;
          end
        end
      end
      ST_DIVO: begin
        if (div_done) begin
          odd_avg_d = div_quot[DATA_W-1:0];
          state_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output word holding register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign pair_lo = (even_avg_q > odd_avg_q) ? odd_avg_q : even_avg_q;
  assign pair_hi = (even_avg_q > odd_avg_q) ? even_avg_q : odd_avg_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      oldest_q    <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      idx_q       <= '0;
      issue_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      idx_q       <= idx_d;
      issue_q     <= issue;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) sample_q <= in_i.sample;
    par_q      <= idx_q[0];
    mean_q     <= mean_d;
    even_avg_q <= even_avg_d;
    odd_avg_q  <= odd_avg_d;
    if (out_load) begin
      omean_q <= mean_q;
      omin_q  <= scan_min;
      omax_q  <= scan_max;
      olow_q  <= pair_lo;
      ohigh_q <= pair_hi;
      ofill_q <= FILL_W'(count_q);
    end
  end

  // scan accumulator, cleared on each new sample
  assign scan_ctl.clear = in_accept;
  assign scan_ctl.valid = issue_q;
  assign scan_ctl.odd   = par_q;

  sws_scan #(
    .SUM_W(SUM_W)
  ) u_scan (
    .clk_i     (clk_i),
    .ctl_i     (scan_ctl),
    .data_i    (mem_rdata_q),
    .min_o     (scan_min),
    .max_o     (scan_max),
    .even_sum_o(even_sum),
    .odd_sum_o (odd_sum)
  );

  sws_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.mean_value = omean_q;
  assign out_o.min_value  = omin_q;
  assign out_o.max_value  = omax_q;
  assign out_o.pair_low   = olow_q;
  assign out_o.pair_high  = ohigh_q;
  assign out_o.fill_count = ofill_q;

`ifndef SYNTH
  // the oldest pointer only moves once the window is full
  a_oldest_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != WinCnt) |-> (oldest_q == '0))
    else $error("oldest slot moved before the window filled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= WinCnt)
    else $error("held count above window size");

  a_fill_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (count_q != WinCnt)) |=> (count_q == CNT_W'($past(count_q) + 1'b1)))
    else $error("held count did not grow on append");

  a_report_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (count_q != '0))
    else $error("report with an empty window");

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((state_q == ST_DIVM) || (state_q == ST_DIVE) || (state_q == ST_DIVO)))
    else $error("divider finished outside a divide step");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for sliding_window_stats; predicts mean, min, max and
// the sorted even/odd position averages of the held window for every sample word.
// Depends on sws_pkg, sws_in_if, sws_out_if and the sliding_window_stats top level.
module tb;
  import sws_pkg::*;

  localparam int unsigned WINDOW = 20;
  localparam int unsigned MAX_WAIT = 18;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct packed {
    word_t mean_value;
    word_t min_value;
    word_t max_value;
    word_t pair_low;
    word_t pair_high;
    fill_t fill_count;
  } stats_t;

  // value shapes for the random runs
  typedef enum int {
    PAT_RANDOM,
    PAT_SMALL,
    PAT_NEAR_MAX,
    PAT_CONSTANT,
    PAT_ALTERNATE,
    PAT_ONE_HOT
  } pattern_e;

  logic clk_i;
  logic rst_ni;
  logic failed;
  logic no_idle;

  word_t  held_samples[$];
  stats_t expected_stats[$];
  stats_t want;
  int     ready_wait;

  sws_in_if  sample_ch ();
  sws_out_if stats_ch ();

  sliding_window_stats #(.WINDOW(WINDOW)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (sample_ch),
    .out_o  (stats_ch)
  );

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // timeout
  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned draw_wait();
    if (no_idle) begin
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // append one sample to the window copy and work out the statistics word
  function automatic stats_t window_stats_after(word_t s);
    stats_t      r;
    logic [63:0] total;
    logic [63:0] even_sum;
    logic [63:0] odd_sum;
    logic [63:0] even_avg;
    logic [63:0] odd_avg;
    int unsigned even_n;
    int unsigned odd_n;
    held_samples = {held_samples, s};
    if (held_samples.size() > WINDOW) begin
      held_samples.delete(0);
    end
    r.min_value = '1;
    r.max_value = '0;
    total = '0;
    even_sum = '0;
    odd_sum = '0;
    even_n = 0;
    odd_n = 0;
    foreach (held_samples[i]) begin
      if (held_samples[i] < r.min_value) r.min_value = held_samples[i];
      if (held_samples[i] > r.max_value) r.max_value = held_samples[i];
      total += held_samples[i];
      if (i % 2 == 0) begin
        even_sum += held_samples[i];
        even_n++;
      end else begin
        odd_sum += held_samples[i];
        odd_n++;
      end
    end
    // an empty group averages to zero
    even_avg = (even_n != 0) ? even_sum / 64'(even_n) : 64'd0;
    odd_avg  = (odd_n != 0) ? odd_sum / 64'(odd_n) : 64'd0;
    r.mean_value = word_t'(total / 64'(held_samples.size()));
    r.pair_low   = word_t'((even_avg > odd_avg) ? odd_avg : even_avg);
    r.pair_high  = word_t'((even_avg > odd_avg) ? even_avg : odd_avg);
    r.fill_count = fill_t'(held_samples.size());
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_sample(word_t s);
    int unsigned gap;
    stats_t      predicted;
    gap = draw_wait();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    do @(posedge clk_i); while (!sample_ch.ready);
    predicted = window_stats_after(s);
    expected_stats = {expected_stats, predicted};
    @(negedge clk_i);
  endtask

  function automatic void check_field(string name, word_t exp_v, word_t act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      failed = 1'b1;
    end
  endfunction

  // compare every accepted statistics word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && stats_ch.valid && stats_ch.ready) begin
      if (expected_stats.size() == 0) begin
        $display("%0t: statistics word with no sample pending, actual mean %h",
                 $time, stats_ch.mean_value);
        failed = 1'b1;
      end else begin
        want = expected_stats[0];
        expected_stats.delete(0);
        check_field("mean_value", want.mean_value, stats_ch.mean_value);
        check_field("min_value", want.min_value, stats_ch.min_value);
        check_field("max_value", want.max_value, stats_ch.max_value);
        check_field("pair_low", want.pair_low, stats_ch.pair_low);
        check_field("pair_high", want.pair_high, stats_ch.pair_high);
        check_field("fill_count", word_t'(want.fill_count), word_t'(stats_ch.fill_count));
      end
    end
  end

  // result side: hold ready low for a drawn number of cycles once a word is offered
  initial begin
    stats_ch.ready = 1'b0;
    forever begin
      ready_wait = draw_wait();
      @(negedge clk_i);
      stats_ch.ready <= (ready_wait == 0);
      if (ready_wait > 0) begin
        do @(posedge clk_i); while (!(rst_ni && stats_ch.valid));
        repeat (ready_wait - 1) @(posedge clk_i);
        @(negedge clk_i);
        stats_ch.ready <= 1'b1;
      end
      do @(posedge clk_i); while (!(rst_ni && stats_ch.valid && stats_ch.ready));
    end
  end

  // first word after reset leaves the odd group empty
  task automatic test_single_sample();
    send_sample('1);
  endtask

  // all-max window fills and wraps, then zero moves from an odd to an even position
  task automatic test_extremes_and_wrap();
    repeat (WINDOW - 1) send_sample('1);
    send_sample('1);
    send_sample('0);
    send_sample('1);
    send_sample(word_t'(1));
    send_sample(32'h8000_0000);
  endtask

  task automatic test_random_windows(int unsigned n_items);
    int unsigned sent;
    int unsigned run_len;
    pattern_e    pat;
    word_t       base;
    word_t       s;
    sent = 0;
    while (sent < n_items) begin
      run_len = $urandom_range(5, 60);
      pat     = pattern_e'($urandom_range(PAT_RANDOM, PAT_ONE_HOT));
      no_idle = ($urandom_range(0, 3) == 0);
      base    = $urandom;
      for (int unsigned k = 0; k < run_len && sent < n_items; k++) begin
        case (pat)
          PAT_RANDOM:    s = $urandom;
          PAT_SMALL:     s = $urandom_range(0, 255);
          PAT_NEAR_MAX:  s = '1 - word_t'($urandom_range(0, 255));
          PAT_CONSTANT:  s = base;
          PAT_ALTERNATE: s = k[0] ? base : ~base;
          default:       s = word_t'(1) << $urandom_range(0, DATA_W - 1);
        endcase
        send_sample(s);
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  // main sequence
  initial begin
    failed = 1'b0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_single_sample();
    test_extremes_and_wrap();
    test_random_windows(1225);

    sample_ch.valid <= 1'b0;
    wait (expected_stats.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
